>>> sv/utf8_stream_decoder_unit_assert.svh
// Assertion macros for the UTF-8 stream decoder; clk and arst_n come from the using module.
`ifndef UTF8_STREAM_DECODER_UNIT_ASSERT_SVH
`define UTF8_STREAM_DECODER_UNIT_ASSERT_SVH

// check c in the same cycle as a
`define USD_ASSERT_NOW(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("decoder assertion failed");

// check c in the cycle after a
`define USD_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("decoder assertion failed");

`endif

>>> sv/usd_pkg.sv
// Types, constants and lead-byte decode shared by the UTF-8 stream decoder.
package usd_pkg;

	localparam logic [7:0] REPL_RESET   = 8'd63;
	localparam logic [1:0] CONT_TAG     = 2'b10;
	localparam logic [2:0] LEN_NONE     = 3'd0;
	localparam logic [2:0] LEN_ONE      = 3'd1;
	localparam logic [2:0] LEN_TWO      = 3'd2;
	localparam logic [2:0] LEN_THREE    = 3'd3;
	localparam logic [2:0] LEN_FOUR     = 3'd4;
	localparam logic [1:0] REM_NONE     = 2'd0;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic        char_valid;
		logic [20:0] code_point;
		logic [7:0]  narrow_char;
		logic [2:0]  seq_length;
		logic        error_now;
		logic        end_of_message;
		logic        message_ok;
	} out_item_t;

	typedef enum logic [2:0] {
		LEAD_ASCII,
		LEAD_TWO,
		LEAD_THREE,
		LEAD_FOUR,
		LEAD_BAD
	} lead_class_t;

	function automatic lead_class_t lead_class(input logic [7:0] b);
		lead_class_t c;
		unique casez (b)
			8'b0???????: c = LEAD_ASCII;
			8'b110?????: c = LEAD_TWO;
			8'b1110????: c = LEAD_THREE;
			8'b11110???: c = LEAD_FOUR;
			default:     c = LEAD_BAD;
		endcase
		return c;
	endfunction

endpackage

>>> sv/utf8_stream_decoder_unit.sv
// Top level of the byte-serial UTF-8 stream decoder.
// Input channel in_valid/in_ready/in_data carries one message byte and its
// last-byte mark per item. Output channel out_valid/out_ready/out_data
// carries one result item: a decoded character, a first error, or the
// end-of-message status. Bytes inside a sequence and bytes after an error
// give no result item unless they carry the last-byte mark.
// An accepted item is decoded from the input register and its result is
// loaded into the result register, from which the receiver takes it.
// Throughput: one byte per cycle while the receiver does not stall, set
// by the single decode step between the input and result registers.
// cfg_we/cfg_wdata write the replacement character (reset 0x3F) used as the
// narrow character for code points above 0x7F; write it only while idle.
// Reset clears the decode state, both registers' valid flags and restores
// the replacement character; in_ready is high right after reset.
// When the receiver stalls, the result register holds; one more byte waits
// in the input register, and bytes that give no result still drain.
module utf8_stream_decoder_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  usd_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output usd_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata
);

	logic [7:0]         repl_char_q;
	logic               valid_s1;
	usd_pkg::in_item_t  data_s1;
	logic               advance;
	logic               emit;
	logic               out_free;
	usd_pkg::out_item_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_char_q <= usd_pkg::REPL_RESET;
		end else if (cfg_we) begin
			repl_char_q <= cfg_wdata;
		end
	end

	usd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	usd_decode u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.data_s1   (data_s1),
		.out_free  (out_free),
		.repl_char (repl_char_q),
		.advance   (advance),
		.emit      (emit),
		.result    (result)
	);

	usd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && emit),
		.result    (result),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

>>> sv/usd_in_stage.sv
// Input register stage of the UTF-8 stream decoder.
module usd_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  usd_pkg::in_item_t in_data,
	input  logic              advance,
	output logic              valid_s1,
	output usd_pkg::in_item_t data_s1
);

	logic valid_q;

	assign in_ready = !valid_q || advance;
	assign valid_s1 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_q <= 1'b1;
		end else if (advance) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

endmodule

>>> sv/usd_decode.sv
// Decode state and single-pass step logic of the UTF-8 stream decoder.
`include "utf8_stream_decoder_unit_assert.svh"

module usd_decode (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s1,
	input  usd_pkg::in_item_t  data_s1,
	input  logic               out_free,
	input  logic [7:0]         repl_char,
	output logic               advance,
	output logic               emit,
	output usd_pkg::out_item_t result
);

	logic [1:0]  rem_q,  rem_d;
	logic [20:0] part_q, part_d;
	logic [2:0]  len_q,  len_d;
	logic        failed_q, failed_d;

	logic        done, err, last;
	logic [7:0]  b;
	logic [20:0] cp, acc;
	logic [2:0]  len;

	assign b    = data_s1.byte_in;
	assign last = data_s1.last_byte;
	assign acc  = {part_q[14:0], b[5:0]};

	always_comb begin
		done     = 1'b0;
		err      = 1'b0;
		cp       = '0;
		len      = usd_pkg::LEN_NONE;
		rem_d    = rem_q;
		part_d   = part_q;
		len_d    = len_q;
		failed_d = failed_q;
		if (!failed_q) begin
			if (rem_q == usd_pkg::REM_NONE) begin
				unique case (usd_pkg::lead_class(b))
					usd_pkg::LEAD_ASCII: begin
						done = 1'b1;
						cp   = {13'd0, b};
						len  = usd_pkg::LEN_ONE;
					end
					usd_pkg::LEAD_TWO: begin
						part_d = {16'd0, b[4:0]};
						rem_d  = 2'd1;
						len_d  = usd_pkg::LEN_TWO;
					end
					usd_pkg::LEAD_THREE: begin
						part_d = {17'd0, b[3:0]};
						rem_d  = 2'd2;
						len_d  = usd_pkg::LEN_THREE;
					end
					usd_pkg::LEAD_FOUR: begin
						part_d = {18'd0, b[2:0]};
						rem_d  = 2'd3;
						len_d  = usd_pkg::LEN_FOUR;
					end
					default: begin
						err = 1'b1;
					end
				endcase
			end else if (b[7:6] != usd_pkg::CONT_TAG) begin
				err = 1'b1;
			end else begin
				rem_d = rem_q - 2'd1;
				if (rem_d == usd_pkg::REM_NONE) begin
					done   = 1'b1;
					cp     = acc;
					len    = len_q;
					part_d = '0;
					len_d  = usd_pkg::LEN_NONE;
				end else begin
					part_d = acc;
				end
			end
			if (!err && last && rem_d != usd_pkg::REM_NONE) begin
				err = 1'b1;
			end
			if (err) begin
				failed_d = 1'b1;
				rem_d    = usd_pkg::REM_NONE;
				part_d   = '0;
				len_d    = usd_pkg::LEN_NONE;
			end
		end

		result.char_valid     = done;
		result.code_point     = cp;
		result.narrow_char    = !done ? 8'd0 : ((cp[20:7] == '0) ? cp[7:0] : repl_char);
		result.seq_length     = len;
		result.error_now      = err;
		result.end_of_message = last;
		result.message_ok     = last && !failed_d;

		if (last) begin
			rem_d    = usd_pkg::REM_NONE;
			part_d   = '0;
			len_d    = usd_pkg::LEN_NONE;
			failed_d = 1'b0;
		end
	end

	assign emit    = done || err || last;
	assign advance = valid_s1 && (!emit || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q    <= usd_pkg::REM_NONE;
			part_q   <= '0;
			len_q    <= usd_pkg::LEN_NONE;
			failed_q <= 1'b0;
		end else if (advance) begin
			rem_q    <= rem_d;
			part_q   <= part_d;
			len_q    <= len_d;
			failed_q <= failed_d;
		end
	end

	`USD_ASSERT_NEXT(a_last_clears, advance && last,
		rem_q == usd_pkg::REM_NONE && len_q == usd_pkg::LEN_NONE && !failed_q)
	`USD_ASSERT_NOW(a_fail_idle, failed_q, rem_q == usd_pkg::REM_NONE)
	`USD_ASSERT_NOW(a_len_tracks, rem_q != usd_pkg::REM_NONE,
		len_q > {1'b0, rem_q})

endmodule

>>> sv/usd_out_stage.sv
// Result register of the UTF-8 stream decoder.
module usd_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  usd_pkg::out_item_t result,
	output logic               out_free,
	output logic               out_valid,
	input  logic               out_ready,
	output usd_pkg::out_item_t out_data
);

	logic               valid_q;
	usd_pkg::out_item_t data_q;

	assign out_free  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && load) begin
			data_q <= result;
		end
	end

endmodule

>>> verif/tb_utf8_stream_decoder_unit.sv
// Testbench for the UTF-8 stream decoder: directed and random byte messages checked against a predictor.
`timescale 1ns / 100ps

module tb_utf8_stream_decoder_unit;

	localparam int          TIMEOUT_NS    = 5_000_000;
	localparam int          DRAIN_LIMIT   = 4000;
	localparam int          SETTLE_CYCLES = 4;
	localparam int          GAP_MAX       = 18;
	localparam logic [20:0] ASCII_TOP     = 21'h7F;

	typedef enum int {
		FLAW_NONE,
		FLAW_NOISE,
		FLAW_CUT,
		FLAW_JUNK
	} flaw_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	usd_pkg::in_item_t  in_data   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	usd_pkg::out_item_t out_data;
	logic               cfg_we    = 1'b0;
	logic [7:0]         cfg_wdata = '0;

	usd_pkg::out_item_t expected_decodes[$];
	int          mismatch_count   = 0;
	int          bytes_sent       = 0;
	int          sink_hold_cycles = 0;
	bit          src_idle         = 1'b1;
	bit          sink_idle        = 1'b1;

	logic [1:0]  rem_cnt    = usd_pkg::REM_NONE;
	logic [20:0] acc_code   = '0;
	logic [2:0]  seq_len_st = usd_pkg::LEN_NONE;
	logic        msg_bad    = 1'b0;
	logic [7:0]  repl_char  = usd_pkg::REPL_RESET;

	utf8_stream_decoder_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void decode_byte(input logic [7:0] b, input logic last);
		usd_pkg::out_item_t r;
		logic        done;
		logic        err;
		logic [20:0] cp;
		logic [2:0]  len;
		done = 1'b0;
		err  = 1'b0;
		cp   = '0;
		len  = usd_pkg::LEN_NONE;
		if (!msg_bad) begin
			if (rem_cnt == usd_pkg::REM_NONE) begin
				casez (b)
					8'b0???????: begin
						cp   = {13'd0, b};
						len  = usd_pkg::LEN_ONE;
						done = 1'b1;
					end
					8'b110?????: begin
						acc_code   = {16'd0, b[4:0]};
						rem_cnt    = 2'd1;
						seq_len_st = usd_pkg::LEN_TWO;
					end
					8'b1110????: begin
						acc_code   = {17'd0, b[3:0]};
						rem_cnt    = 2'd2;
						seq_len_st = usd_pkg::LEN_THREE;
					end
					8'b11110???: begin
						acc_code   = {18'd0, b[2:0]};
						rem_cnt    = 2'd3;
						seq_len_st = usd_pkg::LEN_FOUR;
					end
					default: err = 1'b1;
				endcase
			end else if (b[7:6] != usd_pkg::CONT_TAG) begin
				err = 1'b1;
			end else begin
				acc_code = {acc_code[14:0], b[5:0]};
				rem_cnt  = rem_cnt - 2'd1;
				if (rem_cnt == usd_pkg::REM_NONE) begin
					cp         = acc_code;
					len        = seq_len_st;
					done       = 1'b1;
					acc_code   = '0;
					seq_len_st = usd_pkg::LEN_NONE;
				end
			end
			if (!err && last && rem_cnt != usd_pkg::REM_NONE)
				err = 1'b1;
			if (err) begin
				msg_bad    = 1'b1;
				rem_cnt    = usd_pkg::REM_NONE;
				acc_code   = '0;
				seq_len_st = usd_pkg::LEN_NONE;
			end
		end
		if (done || err || last) begin
			r.char_valid     = done;
			r.code_point     = cp;
			r.narrow_char    = !done ? 8'h00 : (cp <= ASCII_TOP) ? cp[7:0] : repl_char;
			r.seq_length     = len;
			r.error_now      = err;
			r.end_of_message = last;
			r.message_ok     = last && !msg_bad;
			expected_decodes.insert(expected_decodes.size(), r);
		end
		if (last) begin
			rem_cnt    = usd_pkg::REM_NONE;
			acc_code   = '0;
			seq_len_st = usd_pkg::LEN_NONE;
			msg_bad    = 1'b0;
		end
	endfunction

	task automatic compare_field(input string field, input logic [20:0] want,
			input logic [20:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin : check_results
		usd_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_decodes.size() == 0) begin
				$display("%0t: result with none expected, got %0h", $time, out_data);
				mismatch_count++;
			end else begin
				want = expected_decodes.pop_front();
				compare_field("char_valid", 21'(want.char_valid),
					21'(out_data.char_valid));
				compare_field("code_point", want.code_point, out_data.code_point);
				compare_field("narrow_char", 21'(want.narrow_char),
					21'(out_data.narrow_char));
				compare_field("seq_length", 21'(want.seq_length),
					21'(out_data.seq_length));
				compare_field("error_now", 21'(want.error_now),
					21'(out_data.error_now));
				compare_field("end_of_message", 21'(want.end_of_message),
					21'(out_data.end_of_message));
				compare_field("message_ok", 21'(want.message_ok),
					21'(out_data.message_ok));
			end
		end
	end

	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = sink_idle ? $urandom_range(0, GAP_MAX) : 0;
			if (sink_hold_cycles > 0) begin
				stall = sink_hold_cycles;
				sink_hold_cycles = 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		int                gap;
		usd_pkg::in_item_t item;
		gap = src_idle ? $urandom_range(0, GAP_MAX) : 0;
		item.byte_in   = b;
		item.last_byte = last;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		decode_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_char(input logic [20:0] cp, input logic [2:0] len, input bit last,
			input int bad_idx, input int nsend);
		logic [7:0] seq [4];
		int         n;
		int         k;
		n = int'(len);
		case (len)
			usd_pkg::LEN_ONE:   seq[0] = {1'b0, cp[6:0]};
			usd_pkg::LEN_TWO:   seq[0] = {3'b110, cp[10:6]};
			usd_pkg::LEN_THREE: seq[0] = {4'b1110, cp[15:12]};
			default:            seq[0] = {5'b11110, cp[20:18]};
		endcase
		for (k = 1; k < n; k++)
			seq[k] = {usd_pkg::CONT_TAG, cp[6 * (n - 1 - k) +: 6]};
		if (bad_idx >= 0)
			seq[bad_idx] = 8'($urandom_range(0, 255));
		for (k = 0; k < nsend; k++)
			send_byte(seq[k], last && k == nsend - 1);
	endtask

	function automatic logic [20:0] pick_code(input logic [2:0] len);
		logic [20:0] cp;
		case (len)
			usd_pkg::LEN_ONE:   cp = 21'($urandom_range(0, 32'h7F));
			usd_pkg::LEN_TWO:   cp = 21'($urandom_range(0, 32'h7FF));
			usd_pkg::LEN_THREE: cp = 21'($urandom_range(0, 32'hFFFF));
			default:            cp = 21'($urandom_range(0, 32'h1FFFFF));
		endcase
		return cp;
	endfunction

	task automatic wait_drain();
		int n;
		in_valid <= 1'b0;
		n = 0;
		while (expected_decodes.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_replacement(input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		repl_char = value;
	endtask

	task automatic send_random_message();
		flaw_t      flaw;
		int         pick;
		int         nchars;
		int         at;
		int         k;
		int         nsend;
		int         bad;
		logic [2:0] len;
		pick   = $urandom_range(0, 9);
		flaw   = (pick < 7) ? FLAW_NONE : (pick == 7) ? FLAW_NOISE :
			(pick == 8) ? FLAW_CUT : FLAW_JUNK;
		nchars = $urandom_range(1, 8);
		at     = $urandom_range(0, nchars - 1);
		src_idle  = ($urandom_range(0, 3) != 0);
		sink_idle = ($urandom_range(0, 3) != 0);
		for (k = 0; k < nchars; k++) begin
			if (flaw == FLAW_JUNK) begin
				send_byte(8'($urandom_range(0, 255)), k == nchars - 1);
			end else begin
				len   = 3'($urandom_range(1, 4));
				nsend = int'(len);
				bad   = -1;
				if (flaw == FLAW_CUT && k == nchars - 1 && len > usd_pkg::LEN_ONE)
					nsend = $urandom_range(1, len - 1);
				if (flaw == FLAW_NOISE && k == at)
					bad = $urandom_range(0, len - 1);
				send_char(pick_code(len), len, k == nchars - 1, bad, nsend);
			end
		end
	endtask

	task automatic test_char_extremes();
		src_idle  = 1'b1;
		sink_idle = 1'b1;
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_char(21'h000000, usd_pkg::LEN_TWO, 1'b0, -1, 2);
		send_char(21'h0007FF, usd_pkg::LEN_TWO, 1'b0, -1, 2);
		send_char(21'h00FFFF, usd_pkg::LEN_THREE, 1'b0, -1, 3);
		send_char(21'h1FFFFF, usd_pkg::LEN_FOUR, 1'b1, -1, 4);
		wait_drain();
	endtask

	task automatic test_malformed_messages();
		send_byte(8'h80, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h42, 1'b1);
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b1);
		send_byte(8'hF8, 1'b1);
		send_byte(8'hBF, 1'b1);
		wait_drain();
	endtask

	task automatic test_output_stall();
		int k;
		src_idle  = 1'b0;
		sink_idle = 1'b0;
		sink_hold_cycles = 150;
		for (k = 0; k < 40; k++)
			send_byte(8'($urandom_range(0, 32'h7F)), k == 39);
		wait_drain();
	endtask

	task automatic test_random_streams();
		int phase;
		int target;
		for (phase = 0; phase < 4; phase++) begin
			wait_drain();
			case (phase)
				0:       set_replacement(8'h00);
				1:       set_replacement(8'hFF);
				default: set_replacement(8'($urandom_range(0, 255)));
			endcase
			target = bytes_sent + 480;
			while (bytes_sent < target)
				send_random_message();
		end
		wait_drain();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_char_extremes();
		test_malformed_messages();
		test_output_stall();
		test_random_streams();
		if (expected_decodes.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				expected_decodes.size());
			mismatch_count += expected_decodes.size();
		end
		if (mismatch_count == 0) begin
			$display("tb_utf8_stream_decoder_unit: done, clean");
		end else begin
			$display("tb_utf8_stream_decoder_unit: done, errors");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("tb_utf8_stream_decoder_unit: done, errors");
		$finish;
	end

endmodule
